// ----- rtl/core/thsup_pkg.sv -----
// ----------------------------------------------------------------------------
// Heartbeat supervisor package
// Types and constants shared by the supervisor core and its checker.
// ----------------------------------------------------------------------------
package thsup_pkg;

	localparam int TICK_W  = 32;
	localparam int COUNT_W = 16;
	localparam int CH_W    = 3;
	localparam int ACT_W   = 3;
	localparam int MASK_W  = 7;

	localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 32'd1000;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

	localparam logic CMD_BEAT  = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_ACTIVE  = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0]  last;
		logic [TICK_W-1:0]  worst;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage

// ----- rtl/core/task_heartbeat_supervisor.sv -----
// ----------------------------------------------------------------------------
// Task heartbeat supervisor
// A beat passes through ST_BEAT and then ST_DONE before result_valid rises,
// and a beat on a channel out of range goes from ST_IDLE straight to ST_DONE.
// A check scans n channels in ST_SCAN, where n is active_channels capped at
// CHANNELS, and then goes to ST_DONE. The scan sets the check time. The
// per-channel state sits in one memory with a single read port, so a check
// reads one channel per cycle and writes each updated channel back in the
// following cycle. item_ready returns in the cycle in which result_valid
// rises, so no new word is taken while the previous one is in work.
// A new word is taken as soon as the previous result is in the output
// register, even while it waits there. A finished item waits while the output
// register still holds a word that has not been accepted.
// ----------------------------------------------------------------------------
module task_heartbeat_supervisor
	import thsup_pkg::*;
#(
	parameter int CHANNELS = 7
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,

	input  logic                item_valid,
	output logic                item_ready,
	input  logic                cmd,
	input  logic [CH_W-1:0]     channel,
	input  logic [TICK_W-1:0]   now_tick,

	output logic                result_valid,
	input  logic                result_ready,
	output logic [TICK_W-1:0]   beat_interval,
	output logic [TICK_W-1:0]   worst_interval,
	output logic [MASK_W-1:0]   timeout_mask,
	output logic [MASK_W-1:0]   new_timeout_mask
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BEAT,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [TICK_W-1:0]   timeout_q;
	logic [ACT_W-1:0]    active_q;
	logic [TICK_W-1:0]   now_q;
	logic [IDX_W-1:0]    ch_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                pr_valid_s1;
	logic [IDX_W-1:0]    pr_idx_s1;
	logic [TICK_W-1:0]   res_beat_q;
	logic [TICK_W-1:0]   res_worst_q;
	logic [MASK_W-1:0]   res_over_q;
	logic [MASK_W-1:0]   res_fresh_q;
	logic [CHANNELS-1:0] vld_q;

	entry_t              mem [CHANNELS];
	entry_t              rdata_s1;
	logic                rd_vld_s1;
	entry_t              cur;

	logic                cfg_wr;
	logic                accept;
	logic                beat_ok;
	logic [CNT_W-1:0]    scan_n;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;
	logic [TICK_W-1:0]   delta;
	logic [TICK_W-1:0]   worst_new;
	logic                over;
	logic [COUNT_W-1:0]  count_new;
	logic [MASK_W-1:0]   bit_sel;
	logic                out_free;
	logic                out_load;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign beat_ok    = (32'(channel) < 32'(CHANNELS));
	assign out_free   = !result_valid || result_ready;
	assign out_load   = (state_q == ST_DONE) && out_free;

	always_comb begin
		case (paddr[2])
			REG_TIMEOUT: prdata = timeout_q;
			default:     prdata = 32'(active_q);
		endcase
	end

	always_comb begin
		if (32'(active_q) > 32'(CHANNELS)) begin
			scan_n = CNT_W'(CHANNELS);
		end else begin
			scan_n = CNT_W'(active_q);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_idx_q[IDX_W-1:0];
		if (state_q == ST_IDLE) begin
			rd_addr = IDX_W'(channel);
			rd_en   = accept && (cmd == CMD_BEAT) && beat_ok;
		end else if (state_q == ST_SCAN) begin
			rd_en = (rd_idx_q < scan_n);
		end
	end

	assign cur       = rd_vld_s1 ? rdata_s1 : '0;
	assign delta     = now_q - cur.last;
	assign worst_new = (delta > cur.worst) ? delta : cur.worst;
	assign over      = (delta > timeout_q);
	assign bit_sel   = MASK_W'(1) << pr_idx_s1;

	always_comb begin
		if (!over) begin
			count_new = '0;
		end else if (cur.count == COUNT_MAX) begin
			count_new = cur.count;
		end else begin
			count_new = cur.count + COUNT_W'(1);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pr_idx_s1;
		wr_data = cur;
		if (state_q == ST_BEAT) begin
			wr_en         = 1'b1;
			wr_addr       = ch_q;
			wr_data.last  = now_q;
			wr_data.worst = worst_new;
		end else if (state_q == ST_SCAN && pr_valid_s1) begin
			wr_en         = 1'b1;
			wr_data.count = count_new;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1  <= mem[rd_addr];
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			timeout_q        <= TIMEOUT_RESET;
			active_q         <= '0;
			vld_q            <= '0;
			now_q            <= '0;
			ch_q             <= '0;
			rd_idx_q         <= '0;
			pr_valid_s1      <= 1'b0;
			pr_idx_s1        <= '0;
			res_beat_q       <= '0;
			res_worst_q      <= '0;
			res_over_q       <= '0;
			res_fresh_q      <= '0;
			result_valid     <= 1'b0;
			beat_interval    <= '0;
			worst_interval   <= '0;
			timeout_mask     <= '0;
			new_timeout_mask <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_TIMEOUT: timeout_q <= pwdata;
					default:     active_q  <= pwdata[ACT_W-1:0];
				endcase
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q       <= now_tick;
						ch_q        <= IDX_W'(channel);
						rd_idx_q    <= '0;
						pr_valid_s1 <= 1'b0;
						res_beat_q  <= '0;
						res_worst_q <= '0;
						res_over_q  <= '0;
						res_fresh_q <= '0;
						if (cmd == CMD_CHECK) begin
							state_q <= ST_SCAN;
						end else if (beat_ok) begin
							state_q <= ST_BEAT;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_BEAT: begin
					res_beat_q  <= delta;
					res_worst_q <= worst_new;
					state_q     <= ST_DONE;
				end
				ST_SCAN: begin
					if (pr_valid_s1 && over) begin
						res_over_q <= res_over_q | bit_sel;
						if (count_new == COUNT_W'(1)) begin
							res_fresh_q <= res_fresh_q | bit_sel;
						end
					end
					if (rd_en) begin
						pr_valid_s1 <= 1'b1;
						pr_idx_s1   <= rd_idx_q[IDX_W-1:0];
						rd_idx_q    <= rd_idx_q + CNT_W'(1);
					end else begin
						pr_valid_s1 <= 1'b0;
						if (!pr_valid_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						beat_interval    <= res_beat_q;
						worst_interval   <= res_worst_q;
						timeout_mask     <= res_over_q;
						new_timeout_mask <= res_fresh_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/thsup_checker.sv -----
// ----------------------------------------------------------------------------
// Heartbeat supervisor checker
// Port-level checks on the result words of the supervisor.
// ----------------------------------------------------------------------------
module thsup_checker
	import thsup_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_ready,
	input logic [TICK_W-1:0]   beat_interval,
	input logic [TICK_W-1:0]   worst_interval,
	input logic [MASK_W-1:0]   timeout_mask,
	input logic [MASK_W-1:0]   new_timeout_mask
);

	// A stalled result word holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(beat_interval)
			&& $stable(worst_interval) && $stable(timeout_mask)
			&& $stable(new_timeout_mask))
	else $error("result word changed while stalled");

	// A word carries either beat fields or check masks, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (beat_interval == '0 && worst_interval == '0)
			|| (timeout_mask == '0 && new_timeout_mask == '0))
	else $error("beat and check fields mixed");

	// A newly timed-out channel is also timed out.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (new_timeout_mask & ~timeout_mask) == '0)
	else $error("new timeout outside timeout mask");

	// The worst interval covers the reported interval.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> beat_interval <= worst_interval)
	else $error("worst interval below beat interval");

endmodule

bind task_heartbeat_supervisor thsup_checker u_thsup_checker (.*);
